/* hdl/lzhc_pkg.sv */
// ----------------------------------------------------------------------------
// lzhc_pkg - shared definitions for the lz hash-chain longest-match unit
// dictionary geometry, match lengths, command codes and sequencer states
// ----------------------------------------------------------------------------
package lzhc_pkg;

  localparam int DICT_BITS  = 13;
  localparam int MATCH_BITS = 4;
  localparam int MIN_MATCH  = 2;

  localparam int DICT_SIZE  = 1 << DICT_BITS;
  localparam int MAX_MATCH  = (1 << MATCH_BITS) + MIN_MATCH - 1;
  localparam int DICT_DEPTH = DICT_SIZE + MAX_MATCH;

  // dictionary address bits, match length bits
  localparam int DADDR_BITS = $clog2(DICT_DEPTH);
  localparam int LEN_BITS   = $clog2(MAX_MATCH + 1);

  localparam logic [15:0] LINK_NIL          = 16'hFFFF;
  localparam logic [7:0]  CHAIN_LIMIT_RESET = 8'd75;

  // stream payload widths, tdata padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    CMD_WR_DICT = 2'd0,
    CMD_WR_LINK = 2'd1,
    CMD_SEARCH  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINKCHK,
    ST_QUICK,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

/* hdl/lz_hash_chain_longest_match_unit.sv */
// ----------------------------------------------------------------------------
// lz_hash_chain_longest_match_unit - lz77 hash-chain longest-match search
// searches visit up to chain_limit links, each with a quick check and a compare
// throughput: one request at a time; the rate is set by the single read port
//   of the link table and the dual read port of the dictionary, one byte a cycle
// reset: control state is cleared and chain_limit returns to 75; both stores are left
//   as they are and hold nothing valid until written, no clearing pass
// ----------------------------------------------------------------------------
module lz_hash_chain_longest_match_unit
  import lzhc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // address[13:0], byte_value[21:14], link_value[37:22],
  // fallback_position[50:38], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // match_length[4:0], match_position[17:5], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // chain_limit register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);

  // request fields
  logic [13:0]          in_address;
  logic [7:0]           in_byte_value;
  logic [15:0]          in_link_value;
  logic [DICT_BITS-1:0] in_fallback;
  cmd_t                 in_cmd;
  logic                 in_acc;

  assign in_address    = in_tdata[13:0];
  assign in_byte_value = in_tdata[21:14];
  assign in_link_value = in_tdata[37:22];
  assign in_fallback   = in_tdata[38 +: DICT_BITS];
  assign in_cmd        = cmd_t'(in_tuser);
  assign in_acc        = in_tvalid && in_tready;

  // storage
  logic [7:0]  dict_mem [DICT_DEPTH];
  logic [15:0] link_mem [DICT_SIZE];

  // control and search registers
  state_t               state_r, state_nxt;
  logic [DICT_BITS-1:0] pos_r, pos_nxt;
  logic [DICT_BITS-1:0] cur_r, cur_nxt;
  logic [LEN_BITS-1:0]  best_len_r, best_len_nxt;
  logic [DICT_BITS-1:0] best_pos_r, best_pos_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [LEN_BITS-1:0]  j_r, j_nxt;
  logic [7:0]           chain_limit_r;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [LEN_BITS-1:0]  out_len_r, out_len_nxt;
  logic [DICT_BITS-1:0] out_pos_r, out_pos_nxt;

  // memory ports
  logic [DADDR_BITS-1:0] rd_a_addr, rd_b_addr;
  logic [DICT_BITS-1:0]  link_rd_addr;
  logic [7:0]            dict_a_r, dict_b_r;
  logic [15:0]           link_r;
  logic                  dict_we, link_we;

  // compare helpers
  logic                  bytes_eq;
  logic                  adv;
  logic [LEN_BITS-1:0]   j_inc;
  logic [LEN_BITS-1:0]   len_fin;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign bytes_eq  = (dict_a_r == dict_b_r);
  assign j_inc     = j_r + 1'b1;

  // write enables, writes beyond each store are dropped
  assign dict_we = in_acc && (in_cmd == CMD_WR_DICT) && (32'(in_address) < DICT_DEPTH);
  assign link_we = in_acc && (in_cmd == CMD_WR_LINK) && (32'(in_address) < DICT_SIZE);

  // dictionary: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[in_address[DADDR_BITS-1:0]] <= in_byte_value;
    end
    dict_a_r <= dict_mem[rd_a_addr];
    dict_b_r <= dict_mem[rd_b_addr];
  end

  // chain links: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[in_address[DICT_BITS-1:0]] <= in_link_value;
    end
    link_r <= link_mem[link_rd_addr];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      chain_limit_r <= CHAIN_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        chain_limit_r <= cfg_data;
      end
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    best_len_r <= best_len_nxt;
    best_pos_r <= best_pos_nxt;
    cnt_r      <= cnt_nxt;
    j_r        <= j_nxt;
    out_len_r  <= out_len_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  // sequencer: link fetch, quick check on the byte past the best length,
  // then a byte-per-cycle compare streamed from both dictionary ports
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    best_len_nxt  = best_len_r;
    best_pos_nxt  = best_pos_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    out_pos_nxt   = out_pos_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    link_rd_addr  = cur_r;
    adv           = 1'b0;
    len_fin       = j_r;

    // result leaves when taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_SEARCH)) begin
          // position wraps to the dictionary size
          pos_nxt      = in_address[DICT_BITS-1:0];
          cur_nxt      = in_address[DICT_BITS-1:0];
          link_rd_addr = in_address[DICT_BITS-1:0];
          best_len_nxt = LEN_BITS'(MIN_MATCH);
          best_pos_nxt = in_fallback;
          cnt_nxt      = chain_limit_r;
          state_nxt    = ST_LINKCHK;
        end
      end
      ST_LINKCHK: begin
        if (link_r == LINK_NIL) begin
          state_nxt = ST_DONE;
        end else begin
          cur_nxt   = link_r[DICT_BITS-1:0];
          rd_a_addr = DADDR_BITS'(link_r[DICT_BITS-1:0]) + DADDR_BITS'(best_len_r);
          rd_b_addr = DADDR_BITS'(pos_r) + DADDR_BITS'(best_len_r);
          state_nxt = ST_QUICK;
        end
      end
      ST_QUICK: begin
        if (bytes_eq) begin
          rd_a_addr = DADDR_BITS'(cur_r);
          rd_b_addr = DADDR_BITS'(pos_r);
          j_nxt     = '0;
          state_nxt = ST_CMP;
        end else begin
          adv = 1'b1;
        end
      end
      ST_CMP: begin
        rd_a_addr = DADDR_BITS'(cur_r) + DADDR_BITS'(j_inc);
        rd_b_addr = DADDR_BITS'(pos_r) + DADDR_BITS'(j_inc);
        if (bytes_eq && (j_r != LEN_BITS'(MAX_MATCH - 1))) begin
          j_nxt = j_inc;
        end else begin
          len_fin = bytes_eq ? LEN_BITS'(MAX_MATCH) : j_r;
          if (len_fin > best_len_r) begin
            best_len_nxt = len_fin;
            best_pos_nxt = cur_r;
            if (len_fin == LEN_BITS'(MAX_MATCH)) begin
              state_nxt = ST_DONE;
            end else begin
              adv = 1'b1;
            end
          end else begin
            adv = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = best_len_r;
          out_pos_nxt   = best_pos_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // next candidate: count the link, a limit of zero wraps to 256 links
    if (adv) begin
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_nxt == 8'd0) begin
        state_nxt = ST_DONE;
      end else begin
        link_rd_addr = cur_r;
        state_nxt    = ST_LINKCHK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - LEN_BITS - DICT_BITS)'(0), out_pos_r, out_len_r};

  // a search request starts with the link check of its own position
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_SEARCH)) |=> (state_r == ST_LINKCHK))
    else $error("search did not start link walk");

  // the quick check never runs once a full-length match is held
  a_quick_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUICK) |-> (best_len_r < LEN_BITS'(MAX_MATCH)))
    else $error("quick check with maximum length");

  // leaving the done state always presents a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && (!out_valid_r || out_tready)) |=>
      (out_tvalid && (state_r == ST_IDLE)))
    else $error("finished search produced no result");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for the lz hash-chain longest-match unit
// fills small dictionary windows and link chains through the request stream,
// searches them under random back-pressure at several chain limits and checks
// every returned match against a model of the search kept in the bench
// ----------------------------------------------------------------------------
module tb_top
  import lzhc_pkg::*;
();

  // tuser code that the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int REQUEST_TARGET = 1050;
  localparam int MAX_GAP        = 16;
  // receiver hold-off long enough for the block to fill up and stall its input
  localparam int LONG_STALL     = 500;
  // spare cycles after the drain before touching the register
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 50;
  // slowest search walks 256 links, and a long stall may come on top
  localparam int STALL_LIMIT    = 30000;

  typedef struct {
    logic [1:0]  cmd;
    logic [13:0] address;
    logic [7:0]  byte_value;
    logic [15:0] link_value;
    logic [12:0] fallback;
  } request_t;

  typedef struct {
    logic [4:0]  length;
    logic [12:0] position;
  } match_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_data   = '0;

  // bench copy of the block state and register
  logic [7:0]  dict_mem [DICT_DEPTH];
  logic [15:0] link_mem [DICT_SIZE];
  logic [7:0]  chain_limit_now = CHAIN_LIMIT_RESET;

  request_t request_q [$];   // requests waiting for the driver
  match_t   match_q [$];     // matches the block still owes us

  int requests_queued = 0;
  int requests_taken  = 0;
  int fail_count      = 0;
  int stall_cycles    = 0;

  // idling switches and long-stall trigger, set per phase by the stimulus
  bit tx_idle_on       = 1'b0;
  bit rx_idle_on       = 1'b0;
  int long_stall_epoch = 0;

  always #6 clk = ~clk;

  lz_hash_chain_longest_match_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic int draw_gap(input bit idle_on);
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // update the bench state with one accepted request; a search walks the
  // chain and queues the match the block should return
  function automatic void apply_request(input request_t r);
    int unsigned pos, cur, best_len, best_pos, walk_limit, n, j;
    logic [15:0] link;
    match_t      m;
    if (r.cmd == CMD_WR_DICT) begin
      // writes past the dictionary tail are dropped
      if (r.address < DICT_DEPTH)
        dict_mem[r.address] = r.byte_value;
    end else if (r.cmd == CMD_WR_LINK) begin
      if (r.address < DICT_SIZE)
        link_mem[r.address] = r.link_value;
    end else if (r.cmd == CMD_SEARCH) begin
      pos        = 32'(r.address[DICT_BITS-1:0]);   // position wraps to the window
      best_len   = MIN_MATCH;
      best_pos   = 32'(r.fallback);
      // a zero limit behaves as a full wrap of the 8-bit down-counter
      walk_limit = (chain_limit_now == 8'd0) ? 256 : 32'(chain_limit_now);
      cur        = pos;
      for (n = 0; n < walk_limit; n++) begin
        link = link_mem[cur];
        if (link == LINK_NIL)
          break;
        cur = 32'(link[DICT_BITS-1:0]);
        // quick reject on the byte just past the current best
        if (dict_mem[cur + best_len] == dict_mem[pos + best_len]) begin
          for (j = 0; j < MAX_MATCH; j++)
            if (dict_mem[pos + j] != dict_mem[cur + j])
              break;
          // strictly longer only, so the first of equal matches on the chain wins
          if (j > best_len) begin
            best_len = j;
            best_pos = cur;
            if (best_len == MAX_MATCH)
              break;
          end
        end
      end
      m.length   = 5'(best_len);
      m.position = 13'(best_pos);
      match_q.push_back(m);
    end
  endfunction

  // --------------------------------------------------------------------------
  // request driver: one request held on the bus until taken, then a random gap
  // --------------------------------------------------------------------------
  request_t              tx_item;
  logic [IN_TDATA_W-1:0] tx_word;
  int                    tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(tx_item);
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          tx_item = request_q.pop_front();
          // address, byte_value, link_value, fallback_position from bit 0 up
          tx_word        = '0;
          tx_word[13:0]  = tx_item.address;
          tx_word[21:14] = tx_item.byte_value;
          tx_word[37:22] = tx_item.link_value;
          tx_word[50:38] = tx_item.fallback;
          in_tdata  <= tx_word;
          in_tuser  <= tx_item.cmd;
          in_tvalid <= 1'b1;
          tx_gap = draw_gap(tx_idle_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: checks each match in order and draws the receiver stalls
  // --------------------------------------------------------------------------
  match_t rx_exp;
  int     rx_hold       = 0;
  int     rx_epoch_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        // match_length in bits 4:0, match_position in bits 17:5
        if (match_q.size() == 0) begin
          $display("%0t: unexpected match, expected none, actual length %0d position %0d",
                   $time, out_tdata[4:0], out_tdata[17:5]);
          fail_count++;
        end else begin
          rx_exp = match_q.pop_front();
          if (rx_exp.length !== out_tdata[4:0]) begin
            $display("%0t: match_length mismatch, expected %0d, actual %0d",
                     $time, rx_exp.length, out_tdata[4:0]);
            fail_count++;
          end
          if (rx_exp.position !== out_tdata[17:5]) begin
            $display("%0t: match_position mismatch, expected %0d, actual %0d",
                     $time, rx_exp.position, out_tdata[17:5]);
            fail_count++;
          end
        end
        rx_hold = draw_gap(rx_idle_on);
      end
      // long hold-off requested by the stimulus
      if (rx_epoch_seen != long_stall_epoch) begin
        rx_epoch_seen = long_stall_epoch;
        rx_hold = LONG_STALL;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers; unused fields carry random values
  // --------------------------------------------------------------------------
  task automatic queue_request(input logic [1:0] cmd, input logic [13:0] address,
                               input logic [7:0] byte_value, input logic [15:0] link_value,
                               input logic [12:0] fallback);
    request_t r;
    r.cmd        = cmd;
    r.address    = address;
    r.byte_value = byte_value;
    r.link_value = link_value;
    r.fallback   = fallback;
    request_q.push_back(r);
    requests_queued++;
  endtask

  task automatic write_byte(input int address, input logic [7:0] value);
    queue_request(CMD_WR_DICT, 14'(address), value, 16'($urandom), 13'($urandom));
  endtask

  task automatic write_link(input int address, input logic [15:0] value);
    queue_request(CMD_WR_LINK, 14'(address), 8'($urandom), value, 13'($urandom));
  endtask

  task automatic find_match(input int address, input int fallback);
    queue_request(CMD_SEARCH, 14'(address), 8'($urandom), 16'($urandom), 13'(fallback));
  endtask

  // link for a window entry: nil, an earlier entry, or any entry (loops);
  // now and then junk above the dictionary bits that the block must drop
  function automatic logic [15:0] pick_link(input int base, input int width, input int from);
    int unsigned target;
    logic [15:0] v;
    if ($urandom_range(0, 5) == 0)
      return LINK_NIL;
    if (from > base && $urandom_range(0, 3) != 0)
      target = $urandom_range(base, from - 1);
    else
      target = $urandom_range(base, base + width - 1);
    v = 16'(target);
    if ($urandom_range(0, 3) == 0)
      v[15:13] = 3'($urandom_range(0, 7));
    if (v == LINK_NIL)
      v = 16'(target);
    return v;
  endfunction

  // wait until every request is taken and every match returned
  task automatic wait_drained();
    do
      @(posedge clk);
    while (requests_taken != requests_queued || match_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_chain_limit(input logic [7:0] value);
    @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do
      @(posedge clk);
    while (!cfg_ready);
    chain_limit_now = value;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         i, s, ph, base, width, mode, period, steps, pos;
    logic [7:0] pattern [8];
    logic [7:0] sym_a, sym_b, b, lim;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the top of the dictionary, chain limit left at reset
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (i = DICT_SIZE - 2; i < DICT_DEPTH - 1; i++)
      write_byte(i, 8'hFF);
    write_byte(DICT_DEPTH - 1, 8'h00);           // last dictionary byte
    write_link(DICT_SIZE - 2, LINK_NIL);
    write_link(DICT_SIZE - 1, 16'hFFFE);         // junk high bits, points one back
    find_match(DICT_SIZE - 2, 0);                // empty chain, fallback 0
    find_match(2 * DICT_SIZE - 2, DICT_SIZE - 1); // position wraps, top fallback
    find_match(DICT_SIZE - 1, 13'h0AAA);         // full-length match
    queue_request(CMD_UNUSED, 14'h3FFF, 8'hFF, 16'hFFFF, 13'h1FFF);
    write_byte(DICT_DEPTH, 8'h00);               // out-of-range writes, dropped
    write_byte(14'h3FFF, 8'h5A);
    write_link(DICT_SIZE, 16'h0000);
    write_link(14'h3FFF, 16'h1234);
    find_match(DICT_SIZE - 1, 13'h1555);
    write_link(DICT_SIZE - 2, 16'(DICT_SIZE - 1)); // two-entry loop
    find_match(DICT_SIZE - 2, 5);
    write_byte(DICT_SIZE + 3, 8'h00);            // break the run partway
    find_match(DICT_SIZE - 1, 0);

    // random phases: each loads a fresh window and searches only inside it
    ph = 0;
    while (requests_queued < REQUEST_TARGET) begin
      wait_drained();
      case (ph)
        0:       lim = 8'd1;
        1:       lim = 8'd255;
        2:       lim = 8'd0;
        3:       lim = 8'd2;
        4:       lim = CHAIN_LIMIT_RESET;
        default: lim = 8'($urandom_range(1, 255));
      endcase
      set_chain_limit(lim);

      case ($urandom_range(0, 3))
        0:       begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
        1:       begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
        2:       begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
        default: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
      endcase

      width = $urandom_range(4, 40);
      case ($urandom_range(0, 5))
        0:       base = 0;
        1:       base = DICT_SIZE - width;
        default: base = $urandom_range(0, DICT_SIZE - width);
      endcase

      // content: short repeats, two symbols, or noise
      mode   = $urandom_range(0, 2);
      period = $urandom_range(1, 6);
      for (i = 0; i < 8; i++)
        pattern[i] = 8'($urandom);
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      for (i = base; i < base + width + MAX_MATCH - 1; i++) begin
        case (mode)
          0:       b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pattern[(i - base) % period];
          1:       b = $urandom_range(0, 1) ? sym_a : sym_b;
          default: b = 8'($urandom);
        endcase
        write_byte(i, b);
      end
      for (i = base; i < base + width; i++)
        write_link(i, pick_link(base, width, i));

      // one phase holds the receiver off while requests keep coming
      if (ph == 1) begin
        tx_idle_on = 1'b0;
        wait_drained();
        long_stall_epoch++;
      end

      steps = $urandom_range(15, 35);
      for (s = 0; s < steps; s++) begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 2))
              0:       queue_request(CMD_UNUSED, 14'($urandom), 8'($urandom), 16'($urandom),
                                     13'($urandom));
              1:       write_byte($urandom_range(DICT_DEPTH, 16383), 8'($urandom));
              default: write_link($urandom_range(DICT_SIZE, 16383), 16'($urandom));
            endcase
          end
          1: begin
            // rewrite inside the window between searches
            if ($urandom_range(0, 1))
              write_byte(base + $urandom_range(0, width + MAX_MATCH - 2), 8'($urandom));
            else begin
              pos = base + $urandom_range(0, width - 1);
              write_link(pos, pick_link(base, width, pos));
            end
          end
          default: begin
            pos = base + $urandom_range(0, width - 1);
            if ($urandom_range(0, 3) == 0)
              pos += DICT_SIZE;
            find_match(pos, $urandom);
          end
        endcase
      end
      ph++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/lzhc_pkg.sv
hdl/lz_hash_chain_longest_match_unit.sv
dv/tb_top.sv
